>>> rtl/sc16_pkg.sv
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the frame receiver.
package sc16_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_WORD        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND_TYPE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAINS_TYPE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_VERSION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND_LENGTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAINS_LENGTH     = 3'd5;

    // CRC-16/CCITT-FALSE: no reflection, no final xor.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Shortest legal frame: two sync bytes, type, version, two CRC bytes.
    localparam logic [8:0] MIN_FRAME_LEN = 9'd6;

    typedef enum logic [2:0] {
        ST_IGNORED     = 3'd0,
        ST_STORED      = 3'd1,
        ST_CMD_OK      = 3'd2,
        ST_GAINS_OK    = 3'd3,
        ST_BAD_CRC     = 3'd4,
        ST_BAD_VERSION = 3'd5,
        ST_ABANDONED   = 3'd6
    } status_t;

    typedef struct packed {
        logic [15:0] sync_word;
        logic [7:0]  command_type;
        logic [7:0]  gains_type;
        logic [7:0]  protocol_version;
        logic [8:0]  command_length;
        logic [8:0]  gains_length;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  byte_value;
        logic [7:0]  byte_index;
        logic        restart_sync;
        logic [31:0] commands_accepted;
        logic [31:0] gains_accepted;
    } result_t;

    // One byte through the CRC, MSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/sync_crc16_frame_receiver.sv
// Top level of the sync-word framed byte receiver with CRC-16/CCITT-FALSE check.
//
//  Channel  Direction  Handshake         Payload
//  s_       in         s_valid/s_ready   s_rx_byte
//  m_       out        m_valid/m_ready   m_status, m_byte_value, m_byte_index,
//                                        m_restart_sync, m_commands_accepted,
//                                        m_gains_accepted
//  cfg_     in         cfg_wr_en         cfg_wr_index, cfg_wr_data
//
// One byte is taken every cycle while the input side is not stalled. Its transfer
// loads the input register, and the result register takes the byte's result once
// it has room, from where the result leaves on its own transfer.
// The CRC byte update and the frame compare sit between those two registers.
// Reset (synchronous, active low) empties both registers, returns the receiver to
// hunting for the sync word and loads the register defaults.
// When the result register is stalled the input register still takes one more
// byte, so the input side only stalls once both registers hold data.
module sync_crc16_frame_receiver #(
    parameter int MAX_FRAME = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_rx_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [2:0]                      m_status,
    output logic [7:0]                      m_byte_value,
    output logic [7:0]                      m_byte_index,
    output logic                            m_restart_sync,
    output logic [31:0]                     m_commands_accepted,
    output logic [31:0]                     m_gains_accepted,
    input  logic                            cfg_wr_en,
    input  logic [sc16_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [sc16_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import sc16_pkg::*;

    cfg_t    cfg;
    result_t result;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg, in_byte_next;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg, out_next;

    logic advance;
    logic step;
    logic s_fire;

    sc16_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_wr_en),
        .wr_index (cfg_wr_index),
        .wr_data  (cfg_wr_data),
        .cfg      (cfg)
    );

    sc16_frame_engine #(
        .MAX_FRAME (MAX_FRAME)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // The result register can take a new result when it is empty or is being
    // emptied by a transfer this cycle.
    assign advance = !out_valid_reg || m_ready;
    // The byte in the input register is processed, and the frame state moves
    // on, only when its result has somewhere to go.
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_byte_next   = in_byte_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_rx_byte;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = in_valid_reg;
            out_next       = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; the valid flags guard them.
    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
        out_reg     <= out_next;
    end

    assign m_valid             = out_valid_reg;
    assign m_status            = out_reg.status;
    assign m_byte_value        = out_reg.byte_value;
    assign m_byte_index        = out_reg.byte_index;
    assign m_restart_sync      = out_reg.restart_sync;
    assign m_commands_accepted = out_reg.commands_accepted;
    assign m_gains_accepted    = out_reg.gains_accepted;

endmodule

>>> rtl/sc16_cfg_regs.sv
// Configuration register file of the frame receiver.
module sc16_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [sc16_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [sc16_pkg::CFG_DATA_W-1:0] wr_data,
    output sc16_pkg::cfg_t                  cfg
);
    import sc16_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                REG_SYNC_WORD:        cfg_next.sync_word        = wr_data;
                REG_COMMAND_TYPE:     cfg_next.command_type     = wr_data[7:0];
                REG_GAINS_TYPE:       cfg_next.gains_type       = wr_data[7:0];
                REG_PROTOCOL_VERSION: cfg_next.protocol_version = wr_data[7:0];
                REG_COMMAND_LENGTH:   cfg_next.command_length   = wr_data[8:0];
                REG_GAINS_LENGTH:     cfg_next.gains_length     = wr_data[8:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_word        <= '0;
            cfg_reg.command_type     <= '0;
            cfg_reg.gains_type       <= '0;
            cfg_reg.protocol_version <= '0;
            cfg_reg.command_length   <= MIN_FRAME_LEN;
            cfg_reg.gains_length     <= MIN_FRAME_LEN;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/sc16_frame_engine.sv
// Frame state, CRC accumulation and per-byte verdict of the frame receiver.
module sc16_frame_engine #(
    parameter int MAX_FRAME = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    input  sc16_pkg::cfg_t    cfg,
    output sc16_pkg::result_t result
);
    import sc16_pkg::*;

    // The length register is nine bits wide, so the clamp never exceeds 511.
    localparam int LEN_MAX = (MAX_FRAME < 511) ? MAX_FRAME : 511;
    localparam int CNT_W   = $clog2(LEN_MAX + 1);

    function automatic logic [CNT_W-1:0] clamp_len(input logic [8:0] v);
        if (v < MIN_FRAME_LEN) begin
            return CNT_W'(MIN_FRAME_LEN);
        end
        if (int'(v) > LEN_MAX) begin
            return CNT_W'(LEN_MAX);
        end
        return CNT_W'(v);
    endfunction

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [15:0]      crc_reg, crc_next;
    logic             is_gains_reg, is_gains_next;
    logic             ver_good_reg, ver_good_next;
    logic [7:0]       crc_low_reg, crc_low_next;
    logic [31:0]      cmd_cnt_reg, cmd_cnt_next;
    logic [31:0]      gains_cnt_reg, gains_cnt_next;

    logic             abandon;
    logic [CNT_W:0]   pos_plus2;
    logic [CNT_W:0]   len_ext;
    logic [CNT_W-1:0] count_inc;
    logic [15:0]      crc_rx;
    status_t          status;
    logic [7:0]       idx;
    logic             restart;

    always_comb begin
        count_next     = count_reg;
        len_next       = len_reg;
        crc_next       = crc_reg;
        is_gains_next  = is_gains_reg;
        ver_good_next  = ver_good_reg;
        crc_low_next   = crc_low_reg;
        cmd_cnt_next   = cmd_cnt_reg;
        gains_cnt_next = gains_cnt_reg;
        status         = ST_IGNORED;
        idx            = '0;
        restart        = 1'b0;
        abandon        = 1'b0;
        pos_plus2      = {1'b0, count_reg} + (CNT_W+1)'(2);
        len_ext        = {1'b0, len_reg};
        count_inc      = count_reg + CNT_W'(1);
        crc_rx         = {rx_byte, crc_low_reg};

        if (count_reg == CNT_W'(0)) begin
            if (rx_byte == cfg.sync_word[7:0]) begin
                crc_next   = crc16_byte(CRC_INIT, rx_byte);
                count_next = CNT_W'(1);
                status     = ST_STORED;
            end
        end else if (count_reg == CNT_W'(1)) begin
            idx = 8'd1;
            if (rx_byte == cfg.sync_word[15:8]) begin
                crc_next   = crc16_byte(crc_reg, rx_byte);
                count_next = CNT_W'(2);
                status     = ST_STORED;
            end else begin
                abandon = 1'b1;
            end
        end else if (count_reg == CNT_W'(2)) begin
            idx = 8'd2;
            if (rx_byte == cfg.command_type || rx_byte == cfg.gains_type) begin
                // The command type wins when both types are equal.
                is_gains_next = (rx_byte != cfg.command_type);
                len_next      = (rx_byte == cfg.command_type) ?
                                clamp_len(cfg.command_length) :
                                clamp_len(cfg.gains_length);
                crc_next      = crc16_byte(crc_reg, rx_byte);
                count_next    = CNT_W'(3);
                status        = ST_STORED;
            end else begin
                abandon = 1'b1;
            end
        end else begin
            idx    = 8'(count_reg);
            status = ST_STORED;
            if (count_reg == CNT_W'(3)) begin
                ver_good_next = (rx_byte == cfg.protocol_version);
            end
            if (pos_plus2 < len_ext) begin
                crc_next = crc16_byte(crc_reg, rx_byte);
            end else if (pos_plus2 == len_ext) begin
                crc_low_next = rx_byte;
            end
            count_next = count_inc;
            if (count_inc >= len_reg) begin
                if (crc_rx != crc_reg) begin
                    status = ST_BAD_CRC;
                end else if (!ver_good_reg) begin
                    status = ST_BAD_VERSION;
                end else if (is_gains_reg) begin
                    gains_cnt_next = gains_cnt_reg + 32'd1;
                    status         = ST_GAINS_OK;
                end else begin
                    cmd_cnt_next = cmd_cnt_reg + 32'd1;
                    status       = ST_CMD_OK;
                end
                count_next    = '0;
                len_next      = '0;
                crc_next      = CRC_INIT;
                is_gains_next = 1'b0;
                ver_good_next = 1'b0;
                crc_low_next  = '0;
            end
        end

        if (abandon) begin
            status        = ST_ABANDONED;
            count_next    = '0;
            len_next      = '0;
            crc_next      = CRC_INIT;
            is_gains_next = 1'b0;
            ver_good_next = 1'b0;
            crc_low_next  = '0;
            if (rx_byte == cfg.sync_word[7:0]) begin
                crc_next   = crc16_byte(CRC_INIT, rx_byte);
                count_next = CNT_W'(1);
                restart    = 1'b1;
                idx        = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            len_reg       <= '0;
            crc_reg       <= CRC_INIT;
            is_gains_reg  <= 1'b0;
            ver_good_reg  <= 1'b0;
            crc_low_reg   <= '0;
            cmd_cnt_reg   <= '0;
            gains_cnt_reg <= '0;
        end else if (step) begin
            count_reg     <= count_next;
            len_reg       <= len_next;
            crc_reg       <= crc_next;
            is_gains_reg  <= is_gains_next;
            ver_good_reg  <= ver_good_next;
            crc_low_reg   <= crc_low_next;
            cmd_cnt_reg   <= cmd_cnt_next;
            gains_cnt_reg <= gains_cnt_next;
        end
    end

    assign result.status            = status;
    assign result.byte_value        = rx_byte;
    assign result.byte_index        = idx;
    assign result.restart_sync      = restart;
    assign result.commands_accepted = cmd_cnt_next;
    assign result.gains_accepted    = gains_cnt_next;

endmodule

>>> rtl/sc16_checker.sv
// Port-level assertions for the frame receiver and the bind that attaches them.
module sc16_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [7:0]  m_byte_value,
    input logic [7:0]  m_byte_index,
    input logic        m_restart_sync,
    input logic [31:0] m_commands_accepted,
    input logic [31:0] m_gains_accepted
);
    import sc16_pkg::*;

    // A stalled result holds still until its transfer.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_byte_value)
            && $stable(m_byte_index) && $stable(m_commands_accepted)
            && $stable(m_gains_accepted))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // An ignored byte never sits inside a frame.
    a_ignored_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_IGNORED |-> m_byte_index == 8'd0 && !m_restart_sync)
        else $error("ignored byte with frame index or restart");

    // A restart only comes with an abandoned frame and opens the new frame at zero.
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_restart_sync |-> m_status == ST_ABANDONED && m_byte_index == 8'd0)
        else $error("restart without abandon");

endmodule

bind sync_crc16_frame_receiver sc16_checker u_sc16_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_status            (m_status),
    .m_byte_value        (m_byte_value),
    .m_byte_index        (m_byte_index),
    .m_restart_sync      (m_restart_sync),
    .m_commands_accepted (m_commands_accepted),
    .m_gains_accepted    (m_gains_accepted)
);

>>> tb/tb_sync_crc16_frame_receiver.sv
// Self-checking testbench for the sync-word framed byte receiver with CRC-16 check.
`timescale 1ns / 1ps

module tb_sync_crc16_frame_receiver;
    import sc16_pkg::*;

    // The block is built with its default frame ceiling, and the predictor clamps
    // latched lengths against the same figure.
    localparam int FRAME_MAX    = 256;
    localparam int RESET_CYCLES = 7;
    // A generous ceiling on the whole run.
    localparam int CYCLE_LIMIT  = 600000;
    // Length of the deliberate receiver hold-off that fills the block up.
    localparam int HOLD_CYCLES  = 80;
    // Frames longer than this are allowed only once per random phase, so that
    // the large length settings are exercised without dominating the run.
    localparam int LONG_FRAME   = 40;
    localparam int DIR_ROWS     = 28;
    // Row of the directed table at which the second directed setting is loaded.
    localparam int SECOND_CFG_ROW = 7;
    localparam int RAND_PHASES  = 5;

    // Where a directed byte comes from: typed in, or taken from the CRC that the
    // table has built up over the frame so far.
    typedef enum logic [1:0] {
        SRC_LIT,
        SRC_CRC_LO,
        SRC_CRC_LO_BAD,
        SRC_CRC_HI
    } byte_src_t;

    // What a directed byte does to the CRC that the table is building.
    typedef enum logic [1:0] {
        CRC_KEEP,
        CRC_RESTART,
        CRC_ADD
    } crc_acc_t;

    // A pinned note carries a hand-typed expectation for status, index and restart;
    // the counters always come from the predictor.
    typedef struct packed {
        logic        pinned;
        status_t     status;
        logic [7:0]  index;
        logic        restart;
    } pin_note_t;

    typedef struct packed {
        byte_src_t   src;
        logic [7:0]  value;
        crc_acc_t    acc;
        logic        pinned;
        status_t     status;
        logic [7:0]  index;
        logic        restart;
    } dir_row_t;

    localparam pin_note_t NO_PIN = '{1'b0, ST_IGNORED, 8'd0, 1'b0};

    // Every input is at a known level from time zero.
    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_rx_byte    = 8'h00;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [2:0]            m_status;
    logic [7:0]            m_byte_value;
    logic [7:0]            m_byte_index;
    logic                  m_restart_sync;
    logic [31:0]           m_commands_accepted;
    logic [31:0]           m_gains_accepted;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;

    sync_crc16_frame_receiver #(
        .MAX_FRAME (FRAME_MAX)
    ) dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_rx_byte           (s_rx_byte),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_byte_value        (m_byte_value),
        .m_byte_index        (m_byte_index),
        .m_restart_sync      (m_restart_sync),
        .m_commands_accepted (m_commands_accepted),
        .m_gains_accepted    (m_gains_accepted),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_index        (cfg_wr_index),
        .cfg_wr_data         (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mirror of the configuration registers, holding the raw written values.
    // Lengths are clamped only when a type byte latches them, as in the block.
    cfg_t cfg_now = '{16'h0000, 8'h00, 8'h00, 8'h00, 9'd6, 9'd6};

    // The predictor's own copy of the receiver state, starting as after reset.
    logic [8:0]  rx_count    = 9'd0;
    logic [8:0]  rx_len      = 9'd0;
    logic [15:0] rx_crc      = CRC_INIT;
    logic        rx_is_gains = 1'b0;
    logic        rx_ver_ok   = 1'b0;
    logic [7:0]  rx_crc_lo   = 8'h00;
    logic [31:0] n_cmd_ok    = 32'd0;
    logic [31:0] n_gains_ok  = 32'd0;

    // Results still owed by the block, oldest first, and the notes that ride along
    // with each offered byte until its transfer.
    result_t     pending_results [$];
    pin_note_t   offer_notes [$];

    dir_row_t    dir_rows [0:DIR_ROWS-1];

    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          bytes_taken    = 0;
    int          seen_by_status [0:7];
    int          tx_frame_bytes = 0;
    bit          long_sent      = 1'b0;
    bit          tx_steady      = 1'b0;
    bit          hold_req       = 1'b0;

    // CRC-16/CCITT-FALSE over one byte, most significant bit first.
    function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

    // A configured length below the shortest frame, or above the ceiling, is pulled
    // back into range when it is latched.
    function automatic logic [8:0] fit_len(input logic [8:0] v);
        if (v < MIN_FRAME_LEN) begin
            return MIN_FRAME_LEN;
        end
        if (v > FRAME_MAX) begin
            return 9'(FRAME_MAX);
        end
        return v;
    endfunction

    function automatic void drop_frame();
        rx_count    = 9'd0;
        rx_len      = 9'd0;
        rx_crc      = CRC_INIT;
        rx_is_gains = 1'b0;
        rx_ver_ok   = 1'b0;
        rx_crc_lo   = 8'h00;
    endfunction

    // Works out the result that one transferred byte must produce, and moves the
    // predictor's state on by that byte.
    function automatic result_t predict_rx_result(input logic [7:0] b);
        result_t     r;
        logic        abandon;
        logic [8:0]  pos;
        logic [15:0] got_crc;
        r.status       = ST_IGNORED;
        r.byte_value   = b;
        r.byte_index   = 8'd0;
        r.restart_sync = 1'b0;
        abandon        = 1'b0;
        if (rx_count == 9'd0) begin
            // Hunting: only the low sync byte opens a frame.
            if (b == cfg_now.sync_word[7:0]) begin
                rx_crc   = crc_next(CRC_INIT, b);
                rx_count = 9'd1;
                r.status = ST_STORED;
            end
        end else if (rx_count == 9'd1) begin
            r.byte_index = 8'd1;
            if (b == cfg_now.sync_word[15:8]) begin
                rx_crc   = crc_next(rx_crc, b);
                rx_count = 9'd2;
                r.status = ST_STORED;
            end else begin
                abandon = 1'b1;
            end
        end else if (rx_count == 9'd2) begin
            r.byte_index = 8'd2;
            // The command type is tested first, so it wins when both types match.
            if (b == cfg_now.command_type) begin
                rx_is_gains = 1'b0;
                rx_len      = fit_len(cfg_now.command_length);
            end else if (b == cfg_now.gains_type) begin
                rx_is_gains = 1'b1;
                rx_len      = fit_len(cfg_now.gains_length);
            end else begin
                abandon = 1'b1;
            end
            if (!abandon) begin
                rx_crc   = crc_next(rx_crc, b);
                rx_count = 9'd3;
                r.status = ST_STORED;
            end
        end else begin
            pos          = rx_count;
            r.byte_index = pos[7:0];
            r.status     = ST_STORED;
            if (pos == 9'd3) begin
                rx_ver_ok = (b == cfg_now.protocol_version);
            end
            if (int'(pos) + 2 < int'(rx_len)) begin
                rx_crc = crc_next(rx_crc, b);
            end else if (int'(pos) + 2 == int'(rx_len)) begin
                rx_crc_lo = b;
            end
            rx_count = pos + 9'd1;
            if (rx_count >= rx_len) begin
                got_crc = {b, rx_crc_lo};
                // A bad CRC outranks a bad version.
                if (got_crc != rx_crc) begin
                    r.status = ST_BAD_CRC;
                end else if (!rx_ver_ok) begin
                    r.status = ST_BAD_VERSION;
                end else if (rx_is_gains) begin
                    n_gains_ok = n_gains_ok + 32'd1;
                    r.status   = ST_GAINS_OK;
                end else begin
                    n_cmd_ok = n_cmd_ok + 32'd1;
                    r.status = ST_CMD_OK;
                end
                drop_frame();
            end
        end
        if (abandon) begin
            r.status = ST_ABANDONED;
            drop_frame();
            // An abandoning byte that matches the low sync byte opens a new frame.
            if (b == cfg_now.sync_word[7:0]) begin
                rx_crc         = crc_next(CRC_INIT, b);
                rx_count       = 9'd1;
                r.restart_sync = 1'b1;
                r.byte_index   = 8'd0;
            end
        end
        r.commands_accepted = n_cmd_ok;
        r.gains_accepted    = n_gains_ok;
        return r;
    endfunction

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("MISMATCH at cycle %0d: %s got 0x%0h, expected 0x%0h",
                     cycle_count, what, got, want);
        end
    endtask

    // Scoreboard. Everything is sampled at the rising edge, before any of that
    // edge's nonblocking updates land, so the values seen are those the block saw.
    // The result side is handled first: a byte's result can never leave in the
    // same cycle as its own transfer, so an empty store there is a real failure.
    always @(posedge aclk) begin : scoreboard
        result_t   want;
        pin_note_t note;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch("result with nothing owed, status", 32'(m_status), 32'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_status !== want.status) begin
                        flag_mismatch("status", 32'(m_status), 32'(want.status));
                    end
                    if (m_byte_value !== want.byte_value) begin
                        flag_mismatch("byte_value", 32'(m_byte_value), 32'(want.byte_value));
                    end
                    if (m_byte_index !== want.byte_index) begin
                        flag_mismatch("byte_index", 32'(m_byte_index), 32'(want.byte_index));
                    end
                    if (m_restart_sync !== want.restart_sync) begin
                        flag_mismatch("restart_sync", 32'(m_restart_sync),
                                      32'(want.restart_sync));
                    end
                    if (m_commands_accepted !== want.commands_accepted) begin
                        flag_mismatch("commands_accepted", m_commands_accepted,
                                      want.commands_accepted);
                    end
                    if (m_gains_accepted !== want.gains_accepted) begin
                        flag_mismatch("gains_accepted", m_gains_accepted, want.gains_accepted);
                    end
                end
            end
            if (s_valid && s_ready) begin
                note = offer_notes.pop_front();
                want = predict_rx_result(s_rx_byte);
                // Directed rows with a typed expectation override the predicted
                // status, index and restart flag.
                if (note.pinned) begin
                    want.status       = note.status;
                    want.byte_index   = note.index;
                    want.restart_sync = note.restart;
                end
                pending_results.push_back(want);
                seen_by_status[int'(want.status)]++;
                bytes_taken++;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_sync_crc16_frame_receiver failed");
            $finish;
        end
    end

    // Mostly back-to-back, often a short pause, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Receiver side. It stalls at random, with stretches of steady readiness, and
    // on request holds ready low for a long run of cycles counted here, so that
    // both of the block's registers fill and its input stalls.
    initial begin : receiver
        int  stall_left;
        int  span;
        bit  rx_steady;
        stall_left = 0;
        span       = 0;
        rx_steady  = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            span++;
            if (span == 250) begin
                span      = 0;
                rx_steady = ($urandom_range(0, 3) == 0);
            end
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 99) < 20) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Offers one byte and returns at the edge of its transfer. Valid is lowered
    // only when a gap follows, so a back-to-back byte never sees valid drop and
    // rise within one step.
    task automatic offer_byte(input logic [7:0] b, input pin_note_t note);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        offer_notes.push_back(note);
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Waits until every transferred byte has had its result back.
    task automatic wait_drained();
        @(posedge aclk);
        while (pending_results.size() != 0 || offer_notes.size() != 0) @(posedge aclk);
    endtask

    // Writes all six registers on consecutive edges. Only called while idle.
    task automatic apply_config(input cfg_t c);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= REG_SYNC_WORD;
        cfg_wr_data  <= c.sync_word;
        @(posedge aclk);
        cfg_wr_index <= REG_COMMAND_TYPE;
        cfg_wr_data  <= 16'(c.command_type);
        @(posedge aclk);
        cfg_wr_index <= REG_GAINS_TYPE;
        cfg_wr_data  <= 16'(c.gains_type);
        @(posedge aclk);
        cfg_wr_index <= REG_PROTOCOL_VERSION;
        cfg_wr_data  <= 16'(c.protocol_version);
        @(posedge aclk);
        cfg_wr_index <= REG_COMMAND_LENGTH;
        cfg_wr_data  <= 16'(c.command_length);
        @(posedge aclk);
        cfg_wr_index <= REG_GAINS_LENGTH;
        cfg_wr_data  <= 16'(c.gains_length);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_now = c;
    endtask

    function automatic cfg_t random_cfg();
        cfg_t c;
        c.sync_word        = 16'($urandom);
        c.command_type     = 8'($urandom);
        c.gains_type       = 8'($urandom);
        c.protocol_version = 8'($urandom);
        c.command_length   = 9'($urandom_range(0, 24));
        c.gains_length     = 9'($urandom_range(0, 24));
        return c;
    endfunction

    // One unit of random traffic. Most of it is a well-formed frame with random
    // payload; the rest is line noise, a broken sync pair, an unknown type, a
    // wrong version or a corrupted byte.
    task automatic send_frame();
        logic [7:0]  fbuf [0:FRAME_MAX-1];
        logic [15:0] crc;
        logic [8:0]  flen;
        logic        pick_gains;
        int          r;
        int          i;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            offer_byte(8'($urandom), NO_PIN);
            return;
        end
        offer_byte(cfg_now.sync_word[7:0], NO_PIN);
        if (r < 13) begin
            offer_byte(8'($urandom), NO_PIN);
            tx_frame_bytes += 2;
            return;
        end
        offer_byte(cfg_now.sync_word[15:8], NO_PIN);
        if (r < 18) begin
            offer_byte(8'($urandom), NO_PIN);
            tx_frame_bytes += 3;
            return;
        end
        if (cfg_now.command_type == cfg_now.gains_type) begin
            pick_gains = 1'b0;
        end else begin
            pick_gains = 1'($urandom_range(0, 1));
        end
        flen = fit_len(pick_gains ? cfg_now.gains_length : cfg_now.command_length);
        if (flen > LONG_FRAME && long_sent && cfg_now.command_type != cfg_now.gains_type) begin
            pick_gains = !pick_gains;
            flen = fit_len(pick_gains ? cfg_now.gains_length : cfg_now.command_length);
        end
        if (flen > LONG_FRAME) begin
            long_sent = 1'b1;
        end
        fbuf[0] = cfg_now.sync_word[7:0];
        fbuf[1] = cfg_now.sync_word[15:8];
        fbuf[2] = pick_gains ? cfg_now.gains_type : cfg_now.command_type;
        if ($urandom_range(0, 99) < 85) begin
            fbuf[3] = cfg_now.protocol_version;
        end else begin
            fbuf[3] = cfg_now.protocol_version ^ 8'(1 << $urandom_range(0, 7));
        end
        for (i = 4; i < int'(flen) - 2; i++) begin
            fbuf[i] = 8'($urandom);
        end
        crc = CRC_INIT;
        for (i = 0; i < int'(flen) - 2; i++) begin
            crc = crc_next(crc, fbuf[i]);
        end
        fbuf[flen - 2] = crc[7:0];
        fbuf[flen - 1] = crc[15:8];
        if ($urandom_range(0, 99) < 10) begin
            i = $urandom_range(3, int'(flen) - 1);
            fbuf[i] = fbuf[i] ^ 8'(1 << $urandom_range(0, 7));
        end
        // The sync pair has gone out already.
        for (i = 2; i < int'(flen); i++) begin
            offer_byte(fbuf[i], NO_PIN);
        end
        tx_frame_bytes += int'(flen);
    endtask

    // Directed table. Rows 0 to 6 run on the reset setting, where sync, both
    // types and the version are all zero, so the command type wins over gains.
    // Rows 7 onwards run with sync 0xA55A, command 0x01, gains 0x02, version
    // 0x10, a command length written below the minimum and a gains length of 7.
    initial begin
        dir_rows = '{
            '{SRC_LIT,        8'hFF, CRC_KEEP,    1'b1, ST_IGNORED,     8'd0, 1'b0},
            '{SRC_LIT,        8'h00, CRC_RESTART, 1'b1, ST_STORED,      8'd0, 1'b0},
            '{SRC_LIT,        8'h00, CRC_ADD,     1'b1, ST_STORED,      8'd1, 1'b0},
            '{SRC_LIT,        8'h00, CRC_ADD,     1'b1, ST_STORED,      8'd2, 1'b0},
            '{SRC_LIT,        8'h00, CRC_ADD,     1'b1, ST_STORED,      8'd3, 1'b0},
            '{SRC_CRC_LO,     8'h00, CRC_KEEP,    1'b1, ST_STORED,      8'd4, 1'b0},
            '{SRC_CRC_HI,     8'h00, CRC_KEEP,    1'b1, ST_CMD_OK,      8'd5, 1'b0},
            // Wrong second sync byte, then one that restarts the frame.
            '{SRC_LIT,        8'h5A, CRC_RESTART, 1'b1, ST_STORED,      8'd0, 1'b0},
            '{SRC_LIT,        8'h00, CRC_KEEP,    1'b1, ST_ABANDONED,   8'd1, 1'b0},
            '{SRC_LIT,        8'h5A, CRC_RESTART, 1'b1, ST_STORED,      8'd0, 1'b0},
            '{SRC_LIT,        8'h5A, CRC_RESTART, 1'b1, ST_ABANDONED,   8'd0, 1'b1},
            // Unknown type byte equal to the low sync byte, then a plain unknown one.
            '{SRC_LIT,        8'hA5, CRC_ADD,     1'b1, ST_STORED,      8'd1, 1'b0},
            '{SRC_LIT,        8'h5A, CRC_RESTART, 1'b1, ST_ABANDONED,   8'd0, 1'b1},
            '{SRC_LIT,        8'hA5, CRC_ADD,     1'b1, ST_STORED,      8'd1, 1'b0},
            '{SRC_LIT,        8'h77, CRC_KEEP,    1'b1, ST_ABANDONED,   8'd2, 1'b0},
            // Gains frame of seven bytes with a good CRC but the wrong version.
            '{SRC_LIT,        8'h5A, CRC_RESTART, 1'b0, ST_IGNORED,     8'd0, 1'b0},
            '{SRC_LIT,        8'hA5, CRC_ADD,     1'b0, ST_IGNORED,     8'd0, 1'b0},
            '{SRC_LIT,        8'h02, CRC_ADD,     1'b0, ST_IGNORED,     8'd0, 1'b0},
            '{SRC_LIT,        8'h11, CRC_ADD,     1'b0, ST_IGNORED,     8'd0, 1'b0},
            '{SRC_LIT,        8'hFF, CRC_ADD,     1'b0, ST_IGNORED,     8'd0, 1'b0},
            '{SRC_CRC_LO,     8'h00, CRC_KEEP,    1'b0, ST_IGNORED,     8'd0, 1'b0},
            '{SRC_CRC_HI,     8'h00, CRC_KEEP,    1'b1, ST_BAD_VERSION, 8'd6, 1'b0},
            // Command frame, length clamped to six, bad version and bad CRC at once.
            '{SRC_LIT,        8'h5A, CRC_RESTART, 1'b0, ST_IGNORED,     8'd0, 1'b0},
            '{SRC_LIT,        8'hA5, CRC_ADD,     1'b0, ST_IGNORED,     8'd0, 1'b0},
            '{SRC_LIT,        8'h01, CRC_ADD,     1'b0, ST_IGNORED,     8'd0, 1'b0},
            '{SRC_LIT,        8'h33, CRC_ADD,     1'b0, ST_IGNORED,     8'd0, 1'b0},
            '{SRC_CRC_LO_BAD, 8'h00, CRC_KEEP,    1'b0, ST_IGNORED,     8'd0, 1'b0},
            '{SRC_CRC_HI,     8'h00, CRC_KEEP,    1'b1, ST_BAD_CRC,     8'd5, 1'b0}
        };
    end

    // Main sequence: reset once, the directed table, then five random phases, each
    // under its own register setting and written only once the block is idle.
    initial begin : stimulus
        dir_row_t    row;
        logic [7:0]  b;
        logic [15:0] tx_crc;
        cfg_t        c;
        int          budget [0:RAND_PHASES-1];
        int          ph;
        bit          paused;
        budget = '{250, 400, 200, 300, 200};
        tx_crc = CRC_INIT;
        for (int s = 0; s < 8; s++) begin
            seen_by_status[s] = 0;
        end
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            row = dir_rows[i];
            if (i == SECOND_CFG_ROW) begin
                s_valid <= 1'b0;
                wait_drained();
                apply_config('{16'hA55A, 8'h01, 8'h02, 8'h10, 9'd0, 9'd7});
            end
            case (row.src)
                SRC_LIT:        b = row.value;
                SRC_CRC_LO:     b = tx_crc[7:0];
                SRC_CRC_LO_BAD: b = tx_crc[7:0] ^ 8'h01;
                default:        b = tx_crc[15:8];
            endcase
            if (row.acc == CRC_RESTART) begin
                tx_crc = crc_next(CRC_INIT, b);
            end else if (row.acc == CRC_ADD) begin
                tx_crc = crc_next(tx_crc, b);
            end
            offer_byte(b, '{row.pinned, row.status, row.index, row.restart});
        end

        paused = 1'b0;
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin
                    // Extreme types, both lengths written below the minimum.
                    c = '{16'($urandom), 8'h00, 8'hFF, 8'h00, 9'd0, 9'd5};
                end
                1: begin
                    // All-ones sync and version, command length far above the
                    // ceiling, so one long command frame goes through.
                    c = '{16'hFFFF, 8'hFF, 8'h00, 8'hFF, 9'h1FF, 9'd12};
                end
                2: begin
                    // Equal types: every frame is a command frame of seven bytes.
                    c = '{16'($urandom), 8'h5C, 8'h5C, 8'($urandom), 9'd7, 9'd256};
                end
                3: begin
                    c = random_cfg();
                    c.gains_length = 9'd256;
                end
                default: begin
                    c = random_cfg();
                end
            endcase
            s_valid <= 1'b0;
            wait_drained();
            apply_config(c);
            long_sent      = 1'b0;
            tx_frame_bytes = 0;
            if (ph == 1) begin
                // Long receiver hold while the sender keeps offering back to back.
                hold_req  = 1'b1;
                tx_steady = 1'b1;
            end
            while (tx_frame_bytes < budget[ph]) begin
                send_frame();
                if (ph == 1 && !hold_req) begin
                    tx_steady = 1'b0;
                end else if (ph != 1 && $urandom_range(0, 99) < 6) begin
                    tx_steady = !tx_steady;
                end
                if (ph == 3 && !paused && tx_frame_bytes >= 150) begin
                    // The sender stops until everything owed has come back.
                    paused = 1'b1;
                    s_valid <= 1'b0;
                    wait_drained();
                end
            end
        end
        s_valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge aclk);

        $display("Covered %0d bytes over %0d settings: %0d command and %0d gains frames accepted.",
                 bytes_taken, RAND_PHASES + 2, seen_by_status[ST_CMD_OK],
                 seen_by_status[ST_GAINS_OK]);
        $display("Rejects: %0d bad CRC, %0d bad version, %0d abandoned, %0d bytes ignored.",
                 seen_by_status[ST_BAD_CRC], seen_by_status[ST_BAD_VERSION],
                 seen_by_status[ST_ABANDONED], seen_by_status[ST_IGNORED]);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("tb_sync_crc16_frame_receiver passed");
        end else begin
            $display("tb_sync_crc16_frame_receiver failed");
        end
        $finish;
    end

endmodule
